### sv/star_header_packet_deframer_top_assert.svh
// Assertion macros for the star header packet deframer.
`ifndef STAR_HEADER_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define STAR_HEADER_PACKET_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shpd assertion failed");

`endif

### sv/shpd_pkg.sv
// Package with types and constants of the star header packet deframer.
`timescale 1ns / 1ps

package shpd_pkg;

  localparam logic [7:0] STAR_BYTE    = 8'h2A;
  localparam int         HEADER_BYTES = 8;
  localparam int         HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI = HDR_CNT_W'(0);
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO = HDR_CNT_W'(1);
  localparam logic [HDR_CNT_W-1:0] HDR_TYPE   = HDR_CNT_W'(2);
  localparam logic [HDR_CNT_W-1:0] HDR_KEY0   = HDR_CNT_W'(4);

  typedef enum logic [1:0] {
    PHASE_HUNT   = 2'd0,
    PHASE_HEADER = 2'd1,
    PHASE_VALUE  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic [7:0]  command_type;
    logic [31:0] packet_key;
    logic        is_last;
    logic        is_empty;
  } result_t;

endpackage

### sv/shpd_core.sv
// Framing state machine: star hunt, header capture and value pass-through.
`timescale 1ns / 1ps

module shpd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output shpd_pkg::result_t   res_o
);

  shpd_pkg::phase_e                phase_q, phase_d;
  logic [1:0]                      star_run_q, star_run_d;
  logic [shpd_pkg::HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0]                     length_q, length_d;
  logic [7:0]                      type_q, type_d;
  logic [31:0]                     key_q, key_d;
  logic [15:0]                     left_q, left_d;
  logic [15:0]                     left_dec;

  assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;

  always_comb begin
    phase_d    = phase_q;
    star_run_d = star_run_q;
    hdr_cnt_d  = hdr_cnt_q;
    length_d   = length_q;
    type_d     = type_q;
    key_d      = key_q;
    left_d     = left_q;
    case (phase_q)
      shpd_pkg::PHASE_HEADER: begin
        if (hdr_cnt_q == shpd_pkg::HDR_LEN_HI) begin
          length_d = {byte_i, length_q[7:0]};
        end else if (hdr_cnt_q == shpd_pkg::HDR_LEN_LO) begin
          length_d = {length_q[15:8], byte_i};
        end else if (hdr_cnt_q == shpd_pkg::HDR_TYPE) begin
          type_d = byte_i;
        end else if (hdr_cnt_q >= shpd_pkg::HDR_KEY0) begin
          key_d = {key_q[23:0], byte_i};
        end
        if (hdr_cnt_q == shpd_pkg::HDR_LAST) begin
          hdr_cnt_d = '0;
          left_d    = length_q;
          phase_d   = (length_q == 16'd0) ? shpd_pkg::PHASE_HUNT : shpd_pkg::PHASE_VALUE;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 1'b1;
        end
      end
      shpd_pkg::PHASE_VALUE: begin
        left_d = left_dec;
        if (left_dec == 16'd0) begin
          phase_d = shpd_pkg::PHASE_HUNT;
        end
      end
      default: begin
        phase_d = shpd_pkg::PHASE_HUNT;
        if (byte_i == shpd_pkg::STAR_BYTE) begin
          if (star_run_q >= 2'd2) begin
            star_run_d = 2'd0;
            hdr_cnt_d  = '0;
            key_d      = 32'd0;
            phase_d    = shpd_pkg::PHASE_HEADER;
          end else begin
            star_run_d = star_run_q + 2'd1;
          end
        end else begin
          star_run_d = 2'd0;
        end
      end
    endcase
  end

  always_comb begin
    res_valid_o         = 1'b0;
    res_o.data_byte     = byte_i;
    res_o.packet_length = length_d;
    res_o.command_type  = type_d;
    res_o.packet_key    = key_d;
    res_o.is_last       = 1'b0;
    res_o.is_empty      = 1'b0;
    case (phase_q)
      shpd_pkg::PHASE_HEADER: begin
        if (hdr_cnt_q == shpd_pkg::HDR_LAST && length_q == 16'd0) begin
          res_valid_o     = push_i;
          res_o.data_byte = 8'd0;
          res_o.is_last   = 1'b1;
          res_o.is_empty  = 1'b1;
        end
      end
      shpd_pkg::PHASE_VALUE: begin
        res_valid_o   = push_i;
        res_o.is_last = (left_dec == 16'd0);
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= shpd_pkg::PHASE_HUNT;
      star_run_q <= 2'd0;
      hdr_cnt_q  <= '0;
      length_q   <= 16'd0;
      type_q     <= 8'd0;
      key_q      <= 32'd0;
      left_q     <= 16'd0;
    end else if (push_i) begin
      phase_q    <= phase_d;
      star_run_q <= star_run_d;
      hdr_cnt_q  <= hdr_cnt_d;
      length_q   <= length_d;
      type_q     <= type_d;
      key_q      <= key_d;
      left_q     <= left_d;
    end
  end

endmodule

### sv/star_header_packet_deframer_top.sv
// Top level of the star header packet deframer with its output skid stage.
//
//   Channel | Direction | Handshake           | Payload
//   input   | in        | in_valid/in_ready   | in_byte (one received byte)
//   output  | out       | out_valid/out_ready | data byte, header fields, last, empty
//
// One byte is taken each cycle while in_ready_o is high and updates the framing state.
// A result is registered in the result register, or in the skid register on a stall.
// A two-entry output stage (result register plus skid register) keeps the input
// open while one result waits; in_ready_o drops only when both entries are full.
// Reset returns the deframer to the star hunt and empties the output stage.
`timescale 1ns / 1ps
`include "star_header_packet_deframer_top_assert.svh"

module star_header_packet_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [15:0] packet_length_o,
  output logic [7:0]  command_type_o,
  output logic [31:0] packet_key_o,
  output logic        is_last_o,
  output logic        is_empty_o
);

  logic              push;
  logic              res_valid;
  shpd_pkg::result_t res;
  logic              out_valid_q;
  shpd_pkg::result_t out_q;
  logic              skid_valid_q;
  shpd_pkg::result_t skid_q;
  logic              empty_form_ok;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;

  shpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .byte_i      (in_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = out_q.data_byte;
  assign packet_length_o = out_q.packet_length;
  assign command_type_o  = out_q.command_type;
  assign packet_key_o    = out_q.packet_key;
  assign is_last_o       = out_q.is_last;
  assign is_empty_o      = out_q.is_empty;

  assign empty_form_ok = out_q.is_last && out_q.data_byte == 8'd0 &&
                         out_q.packet_length == 16'd0;

  `SHPD_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `SHPD_ASSERT_IMP(a_empty_form, out_valid_q && out_q.is_empty, empty_form_ok)
  `SHPD_ASSERT_NXT(a_skid_holds, skid_valid_q && out_valid_q && !out_ready_i, skid_valid_q && $stable(skid_q))

endmodule

### sim/shpd_checker.sv
// Checker that predicts the deframer results from input beats and compares output beats.
`timescale 1ns / 1ps

module shpd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] packet_length_i,
  input  logic [7:0]  command_type_i,
  input  logic [31:0] packet_key_i,
  input  logic        is_last_i,
  input  logic        is_empty_i,
  output int          fails_o,
  output int          pending_o
);

  shpd_pkg::phase_e                phase_q;
  logic [1:0]                      star_run_q;
  logic [shpd_pkg::HDR_CNT_W-1:0]  hdr_count_q;
  logic [15:0]                     length_q;
  logic [7:0]                      type_q;
  logic [31:0]                     key_q;
  logic [15:0]                     left_q;
  shpd_pkg::result_t               expected_results[$];
  int                              fails = 0;
  int                              pending = 0;

  assign fails_o   = fails;
  assign pending_o = pending;

  function automatic bit deframe_byte(input logic [7:0] b, output shpd_pkg::result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    case (phase_q)
      shpd_pkg::PHASE_HEADER: begin
        if (hdr_count_q == shpd_pkg::HDR_LEN_HI) begin
          length_q[15:8] = b;
        end else if (hdr_count_q == shpd_pkg::HDR_LEN_LO) begin
          length_q[7:0] = b;
        end else if (hdr_count_q == shpd_pkg::HDR_TYPE) begin
          type_q = b;
        end else if (hdr_count_q >= shpd_pkg::HDR_KEY0) begin
          key_q = {key_q[23:0], b};
        end
        if (hdr_count_q == shpd_pkg::HDR_LAST) begin
          hdr_count_q = '0;
          if (length_q == 16'd0) begin
            phase_q = shpd_pkg::PHASE_HUNT;
            res = {8'd0, length_q, type_q, key_q, 1'b1, 1'b1};
            hit = 1'b1;
          end else begin
            left_q  = length_q;
            phase_q = shpd_pkg::PHASE_VALUE;
          end
        end else begin
          hdr_count_q = hdr_count_q + 1'b1;
        end
      end
      shpd_pkg::PHASE_VALUE: begin
        if (left_q != 16'd0) begin
          left_q = left_q - 16'd1;
        end
        if (left_q == 16'd0) begin
          phase_q = shpd_pkg::PHASE_HUNT;
        end
        res = {b, length_q, type_q, key_q, left_q == 16'd0, 1'b0};
        hit = 1'b1;
      end
      default: begin
        phase_q = shpd_pkg::PHASE_HUNT;
        if (b == shpd_pkg::STAR_BYTE) begin
          if (star_run_q >= 2'd2) begin
            star_run_q  = '0;
            hdr_count_q = '0;
            key_q       = '0;
            phase_q     = shpd_pkg::PHASE_HEADER;
          end else begin
            star_run_q = star_run_q + 2'd1;
          end
        end else begin
          star_run_q = '0;
        end
      end
    endcase
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    shpd_pkg::result_t res;
    shpd_pkg::result_t want;
    if (!rst_ni) begin
      phase_q     = shpd_pkg::PHASE_HUNT;
      star_run_q  = '0;
      hdr_count_q = '0;
      length_q    = '0;
      type_q      = '0;
      key_q       = '0;
      left_q      = '0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(in_byte_i, res)) begin
          expected_results.push_back(res);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat expected none actual %0h %0h %0h %0h %0b %0b",
                   $time, data_byte_i, packet_length_i, command_type_i, packet_key_i,
                   is_last_i, is_empty_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(data_byte_i));
          check_field("packet_length", 32'(want.packet_length), 32'(packet_length_i));
          check_field("command_type", 32'(want.command_type), 32'(command_type_i));
          check_field("packet_key", want.packet_key, packet_key_i);
          check_field("is_last", 32'(want.is_last), 32'(is_last_i));
          check_field("is_empty", 32'(want.is_empty), 32'(is_empty_i));
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

### sim/tb.sv
// Testbench top that drives byte streams into the deframer and gives the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  data_byte_o;
  logic [15:0] packet_length_o;
  logic [7:0]  command_type_o;
  logic [31:0] packet_key_o;
  logic        is_last_o;
  logic        is_empty_o;
  int          fails;
  int          pending;
  int          send_idle = 13;
  int          recv_idle = 83;
  int          beats_sent = 0;
  int          cycles = 0;

  always #5 clk_i = ~clk_i;

  star_header_packet_deframer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .data_byte_o    (data_byte_o),
    .packet_length_o(packet_length_o),
    .command_type_o (command_type_o),
    .packet_key_o   (packet_key_o),
    .is_last_o      (is_last_o),
    .is_empty_o     (is_empty_o)
  );

  shpd_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready_o),
    .in_byte_i      (in_byte),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready),
    .data_byte_i    (data_byte_o),
    .packet_length_i(packet_length_o),
    .command_type_i (command_type_o),
    .packet_key_i   (packet_key_o),
    .is_last_i      (is_last_o),
    .is_empty_i     (is_empty_o),
    .fails_o        (fails),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == shpd_pkg::STAR_BYTE) begin
      b = 8'h2B;
    end
    return b;
  endfunction

  task automatic send_header(input logic [15:0] len, input logic [7:0] kind,
                             input logic [31:0] key);
    repeat (3) send_beat(shpd_pkg::STAR_BYTE);
    send_beat(len[15:8]);
    send_beat(len[7:0]);
    send_beat(kind);
    send_beat(8'($urandom_range(255)));
    for (int k = 3; k >= 0; k--) begin
      send_beat(key[8*k +: 8]);
    end
  endtask

  task automatic send_value(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(4) == 0) begin
        send_beat(shpd_pkg::STAR_BYTE);
      end else begin
        send_beat(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic random_packet();
    int noise;
    int pick;
    int len;
    noise = int'($urandom_range(3));
    for (int i = 0; i < noise; i++) begin
      if (i < noise - 1 && $urandom_range(1) == 1) begin
        send_beat(shpd_pkg::STAR_BYTE);
      end else begin
        send_beat(plain_byte());
      end
    end
    pick = int'($urandom_range(99));
    if (pick < 10) begin
      len = 0;
    end else if (pick < 85) begin
      len = int'($urandom_range(8, 1));
    end else if (pick < 97) begin
      len = int'($urandom_range(40, 9));
    end else begin
      len = int'($urandom_range(300, 256));
    end
    send_header(16'(len), 8'($urandom_range(255)), $urandom);
    send_value(len);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_header(16'h0000, 8'h00, 32'h0000_0000);
    send_header(16'h0000, 8'hFF, 32'hFFFF_FFFF);
    send_header(16'h0001, 8'hFF, 32'hFFFF_FFFF);
    send_beat(8'hFF);
    send_header(16'h0002, 8'h00, 32'h0000_0000);
    send_beat(8'h00);
    send_beat(shpd_pkg::STAR_BYTE);
    send_beat(shpd_pkg::STAR_BYTE);
    send_beat(shpd_pkg::STAR_BYTE);
    send_beat(8'h00);
    send_header(16'h0003, shpd_pkg::STAR_BYTE, {4{shpd_pkg::STAR_BYTE}});
    repeat (3) send_beat(shpd_pkg::STAR_BYTE);
    send_beat(8'h55);
    while (beats_sent < 160) random_packet();

    send_idle = 83;
    recv_idle = 13;
    while (beats_sent < 310) random_packet();

    send_idle = 0;
    recv_idle = 0;
    while (beats_sent < 460) random_packet();
    send_header({8'h00, shpd_pkg::STAR_BYTE}, 8'h3C, $urandom);
    send_value(int'(shpd_pkg::STAR_BYTE));
    send_header(16'h0001, 8'hA5, $urandom);
    send_value(1);
    in_valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/shpd_pkg.sv
sv/shpd_core.sv
sv/star_header_packet_deframer_top.sv
sim/shpd_checker.sv
sim/tb.sv
